@@ rtl/bts_pkg.sv @@
// ---------------------------------------------------------------------------
// bts_pkg: shared types and helpers for the binary thinning sub-pass
// Word layouts for the pixel and result channels, register indexes, reset
// values and the neighborhood test used to clear a pixel.
// ---------------------------------------------------------------------------
package bts_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_DW = 11;
  localparam int CFG_IW = 2;

  localparam int RST_FRAME_WIDTH  = 480;
  localparam int RST_FRAME_HEIGHT = 640;
  localparam int MIN_DIM          = 3;

  // Set-neighbor count bounds for a removable pixel
  localparam logic [3:0] NBR_MIN = 4'd2;
  localparam logic [3:0] NBR_MAX = 4'd6;

  typedef enum logic [CFG_IW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SUB_PASS     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic pixel_in;
    logic flush;
  } in_word_t;

  typedef struct packed {
    logic pixel_out;
    logic removed;
    logic last;
  } out_word_t;

  // Window layout: bits [2:0] oldest column, [8:6] newest; within a column
  // bit 0 is two rows up, bit 2 the current row. Center is bit 4.
  function automatic logic zs_cut(logic [8:0] win, logic sub);
    logic [7:0] ring;
    logic [3:0] trans;
    logic [3:0] nset;
    logic       m1;
    logic       m2;
    // ring order p2..p9, clockwise from the pixel above
    ring  = {win[0], win[1], win[2], win[5], win[8], win[7], win[6], win[3]};
    trans = '0;
    nset  = '0;
    for (int k = 0; k < 8; k++) begin
      trans = trans + 4'(!ring[k] && ring[(k + 1) % 8]);
      nset  = nset + 4'(ring[k]);
    end
    if (sub) begin
      m1 = ring[0] & ring[2] & ring[6];
      m2 = ring[0] & ring[4] & ring[6];
    end else begin
      m1 = ring[0] & ring[2] & ring[4];
      m2 = ring[2] & ring[4] & ring[6];
    end
    return (trans == 4'd1) && (nset >= NBR_MIN) && (nset <= NBR_MAX) && !m1 && !m2;
  endfunction

endpackage

@@ rtl/binary_thinning_subpass.sv @@
// ---------------------------------------------------------------------------
// binary_thinning_subpass: one thinning sub-pass over a raster bit stream
// Two-row line store, 3x3 window and neighborhood test. Results trail the
// input by one row plus one pixel; border pixels pass through unchanged.
// ---------------------------------------------------------------------------
// Throughput: one pixel word per cycle while the receiver does not stall; the line
//   store has one read port (stage 0) and one write port (stage 1); a read of the
//   column being written at the same edge takes the write data.
// Flow: a word that yields a result is held in the input register from the
//   accepting edge; its result is loaded into the result register when stage 1
//   advances, which a stalled, full result register holds off. The first
//   frame_width+1 words of a frame yield no result.
// Reset: synchronous, active low. Counters, window and the line store fill
//   count clear at once; no clearing pass, columns not yet written read as 0.
module binary_thinning_subpass
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 4);

  localparam logic [WW-1:0] W_RST = (RST_FRAME_WIDTH > MAX_WIDTH) ?
                                    WW'(MAX_WIDTH) : WW'(RST_FRAME_WIDTH);
  localparam logic [HW-1:0] H_RST = (RST_FRAME_HEIGHT > MAX_HEIGHT) ?
                                    HW'(MAX_HEIGHT) : HW'(RST_FRAME_HEIGHT);

  typedef struct packed {
    logic          x;
    logic [CW-1:0] col;
    logic          rd_zero;
    logic          use_prev;
    logic          res;
    logic          interior;
    logic          last;
  } s1_t;

  // configuration
  logic [WW-1:0] width_r, width_nxt;
  logic [HW-1:0] height_r, height_nxt;
  logic          sub_r, sub_nxt;

  // stage 0 state
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW:0]   fill_r, fill_nxt;

  // line store
  logic [1:0]    lstore [MAX_WIDTH];
  logic [1:0]    rd_r;

  // stage 1 and result
  logic          s1_valid_r;
  s1_t           s1_r, s1_nxt;
  logic [8:0]    win_r, win_nxt;
  logic          out_valid_r;
  out_word_t     out_r, out_nxt;

  logic          in_acc, out_free, s1_adv, s1_load;
  logic          wrap;
  logic [CW-1:0] c;
  logic [RW-1:0] r1, r, oi;
  logic [CW-1:0] oj;
  logic          valid0, interior0, last0;
  logic          x0;
  logic [1:0]    ls;
  logic [2:0]    newcol;
  logic          center, cut;

  assign cfg_ready = 1'b1;

  // clamp written dimensions into [3, max]
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    sub_nxt    = sub_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (32'(cfg_data) < MIN_DIM) width_nxt = WW'(MIN_DIM);
          else if (32'(cfg_data) > MAX_WIDTH) width_nxt = WW'(MAX_WIDTH);
          else width_nxt = WW'(cfg_data);
        end
        REG_FRAME_HEIGHT: begin
          if (32'(cfg_data) < MIN_DIM) height_nxt = HW'(MIN_DIM);
          else if (32'(cfg_data) > MAX_HEIGHT) height_nxt = HW'(MAX_HEIGHT);
          else height_nxt = HW'(cfg_data);
        end
        REG_SUB_PASS: sub_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 drains into the result register or drops a no-result word
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_r.res || out_free);
  assign s1_load  = !s1_valid_r || s1_adv;
  assign in_stall = !s1_load;
  assign in_acc   = in_valid && s1_load;

  // stage 0: raster position, output position and flags
  always_comb begin
    x0   = in_data.flush ? 1'b0 : in_data.pixel_in;
    wrap = 32'(col_cnt_r) >= 32'(width_r);
    c    = wrap ? '0 : col_cnt_r;
    r1   = wrap ? RW'(row_cnt_r + 1'b1) : row_cnt_r;
    r    = (32'(r1) > 32'(height_r) + 1) ? '0 : r1;
    if (c != '0) begin
      valid0 = r >= RW'(1);
      oi     = RW'(r - 1'b1);
      oj     = CW'(c - 1'b1);
    end else begin
      valid0 = r >= RW'(2);
      oi     = RW'(r - 2'd2);
      oj     = CW'(width_r - 1'b1);
    end
    valid0    = valid0 && (32'(oi) < 32'(height_r));
    interior0 = (oi != '0) && (32'(oi) + 2 <= 32'(height_r)) &&
                (oj != '0) && (32'(oj) + 2 <= 32'(width_r));
    last0     = (32'(oi) == 32'(height_r) - 1) && (32'(oj) == 32'(width_r) - 1);

    if (32'(c) + 1 >= 32'(width_r)) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = RW'(r + 1'b1);
    end else begin
      col_cnt_nxt = CW'(c + 1'b1);
      row_cnt_nxt = r;
    end
    // frame end: restart both counters
    if (valid0 && last0) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end

    fill_nxt = ({1'b0, c} >= fill_r) ? {1'b0, c} + 1'b1 : fill_r;

    s1_nxt.x        = x0;
    s1_nxt.col      = c;
    s1_nxt.rd_zero  = {1'b0, c} >= fill_r;
    s1_nxt.use_prev = c == '0;
    s1_nxt.res      = valid0;
    s1_nxt.interior = interior0;
    s1_nxt.last     = last0;
  end

  // stage 1: shift the window and test the center
  always_comb begin
    ls      = s1_r.rd_zero ? 2'b00 : rd_r;
    newcol  = {s1_r.x, ls[0], ls[1]};
    win_nxt = {newcol, win_r[8:3]};
    center  = s1_r.use_prev ? win_r[7] : win_nxt[4];
    cut     = s1_r.interior && zs_cut(win_nxt, sub_r);
    out_nxt.pixel_out = center & !cut;
    out_nxt.removed   = center & cut;
    out_nxt.last      = s1_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= W_RST;
      height_r    <= H_RST;
      sub_r       <= 1'b0;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      fill_r      <= '0;
      win_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      sub_r    <= sub_nxt;
      if (in_acc) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
        fill_r    <= fill_nxt;
      end
      if (s1_adv) begin
        win_r <= win_nxt;
      end
      if (s1_load) begin
        s1_valid_r <= in_acc;
      end
      if (s1_adv && s1_r.res) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
      // a word right behind a write to the same column takes the write data
      rd_r <= (s1_adv && s1_r.col == c) ? {ls[0], s1_r.x} : lstore[c];
    end
    if (s1_adv) begin
      lstore[s1_r.col] <= {ls[0], s1_r.x};
    end
    if (s1_adv && s1_r.res) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // fill count never runs past the line store
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (CW + 1)'(MAX_WIDTH))
    else $error("line store fill count beyond depth");

  // a pixel is never both kept and removed
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.pixel_out && out_r.removed))
    else $error("pixel both kept and removed");

  // border pixels are never cleared
  a_border_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.res && !s1_r.interior) |=> (out_valid_r && !out_r.removed))
    else $error("border pixel removed");

  // input backs up only when both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // row counter stays within the wrap range
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_cnt_r) <= MAX_HEIGHT + 2)
    else $error("row counter out of range");

endmodule

@@ tb/sv/bts_stream_check.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bts_stream_check: result checker for the thinning sub-pass
// Watches the pixel, result and register channels. Keeps its own copy of the
// line history, 3x3 window, raster counters and registers, predicts each
// result word, and compares it field by field in arrival order.
// ---------------------------------------------------------------------------
module bts_stream_check
  import bts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_word_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_word_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              run_done,
  output int                mismatches,
  output int                words_due,
  output int                words_seen,
  output int                pixels_cleared,
  output int                frames_closed,
  output logic              at_frame_start
);

  localparam int MAXW      = DEF_MAX_WIDTH;
  localparam int MAXH      = DEF_MAX_HEIGHT;
  localparam int DUE_DEPTH = 64;

  // per column: bit 1 two rows up, bit 0 one row up
  logic [1:0] col_hist [MAXW];
  logic [8:0] win;
  int         col_pos;
  int         row_pos;
  int         width;
  int         height;
  logic       pass_sel;
  out_word_t  pixels_due [DUE_DEPTH];
  int         due_wr;
  int         due_rd;
  int         errs;
  int         seen;
  int         cleared;
  int         frames;
  bit         closed;

  task automatic flag_error(input string what);
    errs++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int clamp_dim(input logic [CFG_DW-1:0] v, input int hi);
    if (int'(v) < MIN_DIM) return MIN_DIM;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Advance the raster position by one word; return 1 when it yields a pixel.
  function automatic bit thin_next(input in_word_t w, output out_word_t res);
    logic       x;
    logic       prev_mid;
    logic       center;
    logic       cut;
    logic       up;
    logic       right;
    logic       down;
    logic       left;
    logic [1:0] hist;
    logic [7:0] ring;
    int         c;
    int         r;
    int         oi;
    int         oj;
    int         rises;
    bit         ok;
    x = w.flush ? 1'b0 : w.pixel_in;
    if (col_pos >= width) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > height + 1) row_pos = 0;
    c = col_pos;
    r = row_pos;
    hist = col_hist[c];
    col_hist[c] = {hist[0], x};
    prev_mid = win[7];
    win = {x, hist[0], hist[1], win[8:3]};
    // column 0 closes the previous row, so the pixel comes from one row up
    if (c >= 1) begin
      ok = r >= 1;
      oi = r - 1;
      oj = c - 1;
      center = win[4];
    end else begin
      ok = r >= 2;
      oi = r - 2;
      oj = width - 1;
      center = prev_mid;
    end
    if (oi >= height) ok = 1'b0;
    col_pos = c + 1;
    if (col_pos >= width) begin
      col_pos = 0;
      row_pos = r + 1;
    end
    if (!ok) return 1'b0;

    up    = win[3];
    right = win[7];
    down  = win[5];
    left  = win[1];
    // clockwise from the pixel above
    ring  = {win[0], left, win[2], down, win[8], right, win[6], up};
    cut   = 1'b0;
    if (oi >= 1 && oi + 2 <= height && oj >= 1 && oj + 2 <= width) begin
      rises = 0;
      for (int k = 0; k < 8; k++) begin
        if (!ring[k] && ring[(k + 1) % 8]) rises++;
      end
      cut = (rises == 1) && ($countones(ring) >= NBR_MIN) && ($countones(ring) <= NBR_MAX);
      if (pass_sel) cut = cut && !(up & right & left) && !(up & down & left);
      else cut = cut && !(up & right & down) && !(right & down & left);
    end
    res.pixel_out = center & ~cut;
    res.removed   = center & cut;
    res.last      = (oi == height - 1) && (oj == width - 1);
    if (res.last) begin
      col_pos = 0;
      row_pos = 0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    out_word_t made;
    int        nc;
    int        nr;
    if (!rst_n) begin
      foreach (col_hist[i]) col_hist[i] = '0;
      win      = '0;
      col_pos  = 0;
      row_pos  = 0;
      width    = RST_FRAME_WIDTH;
      height   = RST_FRAME_HEIGHT;
      pass_sel = 1'b0;
      due_wr   = 0;
      due_rd   = 0;
      closed   = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width    = clamp_dim(cfg_data, MAXW);
          REG_FRAME_HEIGHT: height   = clamp_dim(cfg_data, MAXH);
          REG_SUB_PASS:     pass_sel = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen++;
        if (due_wr == due_rd) begin
          flag_error($sformatf("result word %0d arrived with nothing expected", seen));
        end else begin
          want = pixels_due[due_rd % DUE_DEPTH];
          due_rd++;
          if (out_data.pixel_out !== want.pixel_out)
            flag_error($sformatf("result %0d pixel_out %b, expected %b",
                                 seen, out_data.pixel_out, want.pixel_out));
          if (out_data.removed !== want.removed)
            flag_error($sformatf("result %0d removed %b, expected %b",
                                 seen, out_data.removed, want.removed));
          if (out_data.last !== want.last)
            flag_error($sformatf("result %0d last %b, expected %b",
                                 seen, out_data.last, want.last));
          cleared += want.removed;
          frames  += want.last;
        end
      end
      if (in_valid && !in_stall) begin
        if (thin_next(in_data, made)) begin
          pixels_due[due_wr % DUE_DEPTH] = made;
          due_wr++;
        end
      end
      if (run_done && !closed) begin
        closed = 1'b1;
        if (due_wr != due_rd)
          flag_error($sformatf("%0d result words never arrived", due_wr - due_rd));
      end
    end
    // where the next word lands, after row advance and wrap
    nc = col_pos;
    nr = row_pos;
    if (nc >= width) begin
      nc = 0;
      nr++;
    end
    if (nr > height + 1) nr = 0;
    at_frame_start <= (nc == 0) && (nr == 0);
    words_due      <= due_wr - due_rd;
    mismatches     <= errs;
    words_seen     <= seen;
    pixels_cleared <= cleared;
    frames_closed  <= frames;
  end

endmodule

@@ tb/sv/tb_binary_thinning_subpass.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_binary_thinning_subpass: stimulus and verdict for the thinning sub-pass
// Streams directed and random binary frames through the block, including
// clamped register values, flush words inside frames and register changes
// mid-frame, with random idling on both sides and a long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_binary_thinning_subpass;
  import bts_pkg::*;

  localparam int WATCH_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 4;
  localparam int TAIL         = 8;
  localparam int WIDE_WORDS   = 40;
  localparam int RANDOM_WORDS = 900;
  localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_word_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data  = '0;
  logic              run_done  = 1'b0;
  logic              at_frame_start;
  int                mismatches;
  int                words_due;
  int                words_seen;
  int                pixels_cleared;
  int                frames_closed;

  bit in_gaps     = 1'b1;
  bit out_gaps    = 1'b1;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int idle_cycles = 0;
  int words_sent  = 0;
  int frame_w     = RST_FRAME_WIDTH;
  int frame_h     = RST_FRAME_HEIGHT;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  binary_thinning_subpass dut (.*);

  bts_stream_check check (.*);

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= out_gaps && ($urandom_range(0, 99) < 12);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCH_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_word(input logic pix, input logic fl);
    @(negedge clk);
    while (in_gaps && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel_in: pix, flush: fl};
    words_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic rest_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    rest_input();
    do @(posedge clk); while (words_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h);
    drain();
    write_reg(REG_FRAME_WIDTH, CFG_DW'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DW'(h));
    frame_w = w;
    frame_h = h;
  endtask

  // Feed flush words until the next word opens a frame.
  task automatic realign();
    rest_input();
    while (!at_frame_start) begin
      put_word(1'($urandom_range(0, 1)), 1'b1);
      rest_input();
    end
  endtask

  // One frame: a solid block plus noise, then the drain words.
  task automatic send_frame(input int dens, input int flush_pct);
    int r0;
    int r1;
    int c0;
    int c1;
    r0 = $urandom_range(0, frame_h - 1);
    r1 = $urandom_range(r0, frame_h - 1);
    c0 = $urandom_range(0, frame_w - 1);
    c1 = $urandom_range(c0, frame_w - 1);
    for (int r = 0; r < frame_h; r++) begin
      for (int c = 0; c < frame_w; c++) begin
        if (flush_pct != 0 && $urandom_range(0, 99) < flush_pct)
          put_word(1'($urandom_range(0, 1)), 1'b1);
        else
          put_word((r >= r0 && r <= r1 && c >= c0 && c <= c1) ||
                   ($urandom_range(0, 99) < dens), 1'b0);
      end
    end
    repeat (frame_w + 1) put_word(1'($urandom_range(0, 1)), 1'b1);
  endtask

  initial begin : stimulus
    int pick;
    int n;
    int random_from;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry, then shrink mid-row and clamp from below
    put_word(1'b1, 1'b0);
    put_word(1'b0, 1'b1);
    put_word(1'b1, 1'b1);
    put_word(1'b0, 1'b0);
    drain();
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, CFG_DW'(2));
    write_reg(REG_SUB_PASS, CFG_DW'(1));
    frame_w = MIN_DIM;
    frame_h = MIN_DIM;
    realign();

    // removable center: ring holds only the lower and lower-right pixels
    put_word(1'b0, 1'b0); put_word(1'b0, 1'b0); put_word(1'b0, 1'b0);
    put_word(1'b0, 1'b0); put_word(1'b1, 1'b0); put_word(1'b0, 1'b0);
    put_word(1'b0, 1'b0); put_word(1'b1, 1'b0); put_word(1'b1, 1'b0);
    put_word(1'b1, 1'b1); put_word(1'b0, 1'b1); put_word(1'b0, 1'b1);
    put_word(1'b0, 1'b1);

    // clamp from above, open a full-size frame, then reshape under the stream
    drain();
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, '1);
    write_reg(REG_SUB_PASS, '0);
    frame_w = DEF_MAX_WIDTH;
    frame_h = DEF_MAX_HEIGHT;
    repeat (WIDE_WORDS) put_word(1'($urandom_range(0, 1)), 1'b0);
    set_frame(MIN_DIM, 4);
    realign();

    // two frames back to back, no idling on either side
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    set_frame(12, 8);
    send_frame(30, 0);
    send_frame(40, 10);
    in_gaps  = 1'b1;
    out_gaps = 1'b1;

    // hold the receiver while words keep coming, so the block backs up
    set_frame(12, 8);
    hold_req = 1'b1;
    send_frame(25, 0);
    drain();

    random_from = words_sent;
    while (words_sent - random_from < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        if ($urandom_range(0, 99) < 40) begin
          set_frame(($urandom_range(0, 3) == 0) ? MIN_DIM : $urandom_range(3, 12),
                    $urandom_range(3, 8));
          if ($urandom_range(0, 1)) write_reg(REG_SUB_PASS, CFG_DW'($urandom_range(0, 2047)));
        end
        send_frame($urandom_range(0, 60), (pick < 70) ? 0 : 15);
      end else if (pick < 95) begin
        // break off inside a frame and change geometry under the stream
        n = $urandom_range(1, frame_w * frame_h);
        repeat (n) put_word(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
        set_frame($urandom_range(3, 12), $urandom_range(3, 8));
        repeat ($urandom_range(0, 6)) put_word(1'($urandom_range(0, 1)), 1'b0);
        realign();
      end else begin
        drain();
        write_reg(CFG_IW'($urandom_range(0, 3)), CFG_DW'($urandom_range(0, 2047)));
        repeat ($urandom_range(1, 12))
          put_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        set_frame($urandom_range(3, 12), $urandom_range(3, 8));
        realign();
      end
    end

    drain();
    write_reg(REG_SPARE, '1);
    repeat (TAIL) @(posedge clk);
    @(negedge clk);
    run_done <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    $display("covered %0d pixel words, %0d result words, %0d pixels cleared, %0d frame ends",
             words_sent, words_seen, pixels_cleared, frames_closed);
    $display("clamped size writes, small frames, both sub-passes, flush words, mid-frame reshape");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
